/* sv/telnet_option_refusal_filter_core_assert.svh */
// Assertion macros used by the filter queue RTL
`ifndef TELNET_OPTION_REFUSAL_FILTER_CORE_ASSERT_SVH
`define TELNET_OPTION_REFUSAL_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TOFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TOFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tofc_pkg.sv */
package tofc_pkg;

    localparam int LINE_CAPACITY = 80;
    localparam int LINE_LEN_W    = 7;
    localparam int IDLE_W        = 16;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 16'd30;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_LF   = 8'd10;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    localparam logic REG_IDLE_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5
    } parser_state_t;

    typedef enum logic [2:0] {
        K_CHAR  = 3'd0,
        K_END   = 3'd1,
        K_CLEAR = 3'd2,
        K_REPLY = 3'd3,
        K_CLOSE = 3'd4,
        K_DROP  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        JOB_ONE   = 2'd0,
        JOB_CLEAR = 2'd1,
        JOB_REPLY = 2'd2
    } job_op_t;

    // Work handed from the parser to the result sequencer
    typedef struct packed {
        job_op_t    op;
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] verb;
    } job_t;

endpackage

/* sv/tofc_front.sv */
module tofc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       cmd,
    input  logic [7:0]                 rx_byte,
    input  logic [tofc_pkg::IDLE_W-1:0] idle_limit,
    input  logic                       q_full,
    output logic                       in_stall,
    output logic                       q_push,
    output tofc_pkg::job_t             q_job
);
    import tofc_pkg::*;

    parser_state_t          state_reg, state_next;
    logic [LINE_LEN_W-1:0]  line_len_reg, line_len_next;
    logic [IDLE_W-1:0]      idle_cnt_reg, idle_cnt_next;
    logic [IDLE_W-1:0]      idle_inc;
    logic                   accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign idle_inc = (idle_cnt_reg == {IDLE_W{1'b1}}) ? idle_cnt_reg
                                                       : idle_cnt_reg + 1'b1;

    // Classify the transaction and advance parser, line and idle state
    always_comb
    begin
        state_next    = state_reg;
        line_len_next = line_len_reg;
        idle_cnt_next = idle_cnt_reg;
        q_push        = 1'b0;
        q_job.op      = JOB_ONE;
        q_job.kind    = K_CHAR;
        q_job.value   = rx_byte;
        q_job.verb    = B_DONT;
        if (accept)
        begin
            if (cmd == CMD_POLL)
            begin
                idle_cnt_next = idle_inc;
                if (idle_inc > idle_limit)
                begin
                    state_next    = PS_NORMAL;
                    line_len_next = '0;
                    idle_cnt_next = '0;
                    q_push        = 1'b1;
                    q_job.kind    = K_CLOSE;
                    q_job.value   = '0;
                end
            end
            else
            begin
                idle_cnt_next = '0;
                case (state_reg)
                    PS_IAC:
                    begin
                        state_next = PS_NORMAL;
                        if (rx_byte == B_IAC)
                        begin
                            // Escaped IAC: clear, then store 0xFF as first char
                            line_len_next = LINE_LEN_W'(1);
                            q_push        = 1'b1;
                            q_job.op      = JOB_CLEAR;
                        end
                        else if (rx_byte == B_WILL)
                            state_next = PS_WILL;
                        else if (rx_byte == B_WONT)
                            state_next = PS_WONT;
                        else if (rx_byte == B_DO)
                            state_next = PS_DO;
                        else if (rx_byte == B_DONT)
                            state_next = PS_DONT;
                    end
                    PS_WILL, PS_WONT:
                    begin
                        state_next = PS_NORMAL;
                        q_push     = 1'b1;
                        q_job.op   = JOB_REPLY;
                        q_job.verb = B_DONT;
                    end
                    PS_DO, PS_DONT:
                    begin
                        state_next = PS_NORMAL;
                        q_push     = 1'b1;
                        q_job.op   = JOB_REPLY;
                        q_job.verb = B_WONT;
                    end
                    default:
                    begin
                        state_next = PS_NORMAL;
                        if (rx_byte == B_IAC)
                            state_next = PS_IAC;
                        else if (rx_byte == B_LF)
                        begin
                            line_len_next = '0;
                            q_push        = 1'b1;
                            q_job.kind    = K_END;
                            q_job.value   = '0;
                        end
                        else if (rx_byte != B_CR)
                        begin
                            q_push = 1'b1;
                            if (line_len_reg < LINE_LEN_W'(LINE_CAPACITY))
                            begin
                                line_len_next = line_len_reg + 1'b1;
                                q_job.kind    = K_CHAR;
                            end
                            else
                                q_job.kind = K_DROP;
                        end
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PS_NORMAL;
            line_len_reg <= '0;
            idle_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            line_len_reg <= line_len_next;
            idle_cnt_reg <= idle_cnt_next;
        end
    end

endmodule

/* sv/tofc_queue.sv */
`include "telnet_option_refusal_filter_core_assert.svh"

module tofc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tofc_pkg::job_t push_job,
    input  logic           pop,
    output tofc_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import tofc_pkg::*;

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `TOFC_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
    `TOFC_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
    `TOFC_ASSERT_NEXT(a_fill_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "count did not grow on push")
    `TOFC_ASSERT_NEXT(a_ptr_gap, clk, rst_n, 1'b1, (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0], "pointer gap disagrees with count")

endmodule

/* sv/tofc_back.sv */
module tofc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  tofc_pkg::job_t q_head,
    output logic           q_pop,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [2:0]     kind,
    output logic [7:0]     value,
    output logic           last
);
    import tofc_pkg::*;

    logic [1:0] beat_reg, beat_next;
    logic       valid_reg, valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic       last_reg, last_next;
    kind_t      b_kind;
    logic [7:0] b_value;
    logic       b_last;
    logic       load;

    assign load      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    // Expand the head job into its current result beat
    always_comb
    begin
        b_kind  = q_head.kind;
        b_value = q_head.value;
        b_last  = 1'b1;
        case (q_head.op)
            JOB_CLEAR:
            begin
                if (beat_reg == 2'd0)
                begin
                    b_kind  = K_CLEAR;
                    b_value = '0;
                    b_last  = 1'b0;
                end
                else
                begin
                    b_kind  = K_CHAR;
                    b_value = B_IAC;
                end
            end
            JOB_REPLY:
            begin
                b_kind = K_REPLY;
                case (beat_reg)
                    2'd0:
                    begin
                        b_value = B_IAC;
                        b_last  = 1'b0;
                    end
                    2'd1:
                    begin
                        b_value = q_head.verb;
                        b_last  = 1'b0;
                    end
                    default: b_value = q_head.value;
                endcase
            end
            default: ;
        endcase
    end

    // Load the output register when it is free or being taken
    always_comb
    begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                kind_next  = b_kind;
                value_next = b_value;
                last_next  = b_last;
                if (b_last)
                begin
                    q_pop     = 1'b1;
                    beat_next = '0;
                end
                else
                    beat_next = beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

endmodule

/* sv/telnet_option_refusal_filter_core.sv */
// Path: a transaction's first result passes the job queue, then the output register.
// Throughput: one transaction per cycle while the job queue is not full; a reply job
// gives three result beats and an escaped IAC two, during which the four-entry job
// queue absorbs new input. Reset: rst_n clears the parser, line length, idle count,
// queue and output; idle_limit returns to 30.
module telnet_option_refusal_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic [7:0]                    value,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tofc_pkg::PADDR_W-1:0]  paddr,
    input  logic [tofc_pkg::PDATA_W-1:0]  pwdata,
    output logic [tofc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tofc_pkg::*;

    logic [IDLE_W-1:0] idle_limit_reg;
    logic              q_push, q_pop, q_full, q_empty;
    job_t              q_job, q_head;

    // Register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDLE_LIMIT)
                    ? {{(PDATA_W-IDLE_W){1'b0}}, idle_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_limit_reg <= IDLE_LIMIT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_LIMIT)
            idle_limit_reg <= pwdata[IDLE_W-1:0];
    end

    tofc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .idle_limit (idle_limit_reg),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    tofc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tofc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

endmodule
